>>> src/pgf_pkg.sv
package pgf_pkg;

    // channel and entry geometry
    localparam int COLOR_W = 8;
    localparam int NUM_CH  = 3;
    localparam int PIXEL_W = COLOR_W * NUM_CH;

    // command codes
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_BLEND = 2'd2
    } cmd_t;

    // write target codes
    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_ALL   = 2'd3
    } chan_t;

    // sequencer states
    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_WRAP     = 8'b0000_0100,
        S_FETCH_A  = 8'b0000_1000,
        S_FETCH_LO = 8'b0001_0000,
        S_FETCH_HI = 8'b0010_0000,
        S_DIVIDE   = 8'b0100_0000,
        S_FILL     = 8'b1000_0000
    } state_t;

endpackage

>>> src/pgf_ram.sv
module pgf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/palette_gradient_fill.sv
// Palette gradient fill: a palette of ENTRIES RGB entries, 8 bits per channel.
// Commands enter on start while busy is low; command, index_a, index_b,
// channel and the three color inputs are sampled at that edge. Every command
// gives exactly one result, shown for one cycle with result_valid high:
// red_out, green_out, blue_out hold entry index_a after the command, and
// blend_done says whether a blend rewrote entries. The receiver cannot stall.
// Indices are reduced modulo ENTRIES by repeated subtraction, one step a
// cycle (none when ENTRIES is 256 or more).
// Read or write: S_WRAP reduces the indices and issues the registered palette
// read, then S_FETCH_A forms the result; a write also writes the entry back.
// Blend: after the reduction, S_FETCH_LO and S_FETCH_HI read both endpoints;
// the three channel steps come from bit-serial dividers, one quotient bit a
// cycle, then one entry is written per cycle through the single write port.
// A blend closer than two entries apart behaves as a read.
// After reset the block runs a clearing pass that writes
// gray (j mod 256) into each entry j; busy stays high until it ends.
module palette_gradient_fill #(
    parameter int ENTRIES       = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] index_a,
    input  logic [7:0] index_b,
    input  logic [1:0] channel,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       result_valid,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic       blend_done
);

    import pgf_pkg::*;

    localparam int AW    = $clog2(ENTRIES);
    localparam int NW    = COLOR_W + FRACTION_BITS;
    localparam int ACC_W = NW + 2;
    localparam int CNT_W = $clog2(NW);
    localparam logic [7:0] ENT8 = (ENTRIES < 256) ? 8'(ENTRIES) : 8'd0;

    // control state
    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             result_valid_reg, result_valid_next;

    // payload state
    logic [1:0]         command_reg, command_next;
    logic [1:0]         channel_reg, channel_next;
    logic [7:0]         a_reg, a_next;
    logic [7:0]         b_reg, b_next;
    logic [7:0]         lo_reg, lo_next;
    logic [7:0]         hi_reg, hi_next;
    logic [7:0]         sep_reg, sep_next;
    logic [7:0]         j_reg, j_next;
    logic [PIXEL_W-1:0] wdata_reg, wdata_next;
    logic [PIXEL_W-1:0] lo_val_reg, lo_val_next;
    logic [PIXEL_W-1:0] hi_val_reg, hi_val_next;
    logic [PIXEL_W-1:0] out_reg, out_next;
    logic               done_reg, done_next;

    // per-channel divider and accumulator
    logic [7:0]       rem_reg [NUM_CH];
    logic [7:0]       rem_next [NUM_CH];
    logic [NW-1:0]    num_reg [NUM_CH];
    logic [NW-1:0]    num_next [NUM_CH];
    logic [NW-1:0]    quo_reg [NUM_CH];
    logic [NW-1:0]    quo_next [NUM_CH];
    logic             neg_reg [NUM_CH];
    logic             neg_next [NUM_CH];
    logic [ACC_W-1:0] acc_reg [NUM_CH];
    logic [ACC_W-1:0] acc_next [NUM_CH];

    // memory port
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [PIXEL_W-1:0] ram_wr_data;
    logic [AW-1:0]      ram_rd_addr;
    logic [PIXEL_W-1:0] ram_rd_data;

    // index reduction and endpoint ordering
    logic       a_in_range;
    logic       b_in_range;
    logic [7:0] lo_c;
    logic [7:0] hi_c;
    logic [7:0] sep_c;
    logic       blend_ok;

    assign a_in_range = (ENTRIES >= 256) || (int'(a_reg) < ENTRIES);
    assign b_in_range = (ENTRIES >= 256) || (int'(b_reg) < ENTRIES);
    assign lo_c       = (a_reg < b_reg) ? a_reg : b_reg;
    assign hi_c       = (a_reg < b_reg) ? b_reg : a_reg;
    assign sep_c      = hi_c - lo_c;
    assign blend_ok   = (command_reg == CMD_BLEND) && (sep_c >= 8'd2);

    pgf_ram #(
        .WIDTH(PIXEL_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // read address follows the sequencer
    always_comb
    begin
        case (state_reg)
            S_WRAP:     ram_rd_addr = blend_ok ? AW'(lo_c) : AW'(a_reg);
            S_FETCH_LO: ram_rd_addr = AW'(hi_reg);
            default:    ram_rd_addr = AW'(a_reg);
        endcase
    end

    // sequencer and datapath
    always_comb
    begin
        logic [7:0]         lo_ch;
        logic [7:0]         hi_ch;
        logic [8:0]         trial;
        logic [ACC_W-1:0]   qx;
        logic [ACC_W-1:0]   acc_sum;
        logic [7:0]         sat;
        logic [PIXEL_W-1:0] merged;

        lo_ch             = 8'd0;
        hi_ch             = 8'd0;
        trial             = 9'd0;
        qx                = {ACC_W{1'b0}};
        acc_sum           = {ACC_W{1'b0}};
        sat               = 8'd0;
        state_next        = state_reg;
        clr_next          = clr_reg;
        cnt_next          = cnt_reg;
        result_valid_next = 1'b0;
        command_next      = command_reg;
        channel_next      = channel_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        sep_next          = sep_reg;
        j_next            = j_reg;
        wdata_next        = wdata_reg;
        lo_val_next       = lo_val_reg;
        hi_val_next       = hi_val_reg;
        out_next          = out_reg;
        done_next         = done_reg;
        rem_next          = rem_reg;
        num_next          = num_reg;
        quo_next          = quo_reg;
        neg_next          = neg_reg;
        acc_next          = acc_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = AW'(a_reg);
        ram_wr_data       = {PIXEL_W{1'b0}};
        merged            = ram_rd_data;

        case (state_reg)
            // gray fill after reset
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = {NUM_CH{8'(clr_reg)}};
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == AW'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // command transfer
            S_IDLE:
            begin
                if (start)
                begin
                    command_next = command;
                    channel_next = channel;
                    a_next       = index_a;
                    b_next       = index_b;
                    wdata_next   = {red_in, green_in, blue_in};
                    state_next   = S_WRAP;
                end
            end

            // reduce indices, then issue the first read
            S_WRAP:
            begin
                if (!a_in_range)
                begin
                    a_next = a_reg - ENT8;
                end
                if (!b_in_range)
                begin
                    b_next = b_reg - ENT8;
                end
                if (a_in_range && b_in_range)
                begin
                    lo_next  = lo_c;
                    hi_next  = hi_c;
                    sep_next = sep_c;
                    if (blend_ok)
                    begin
                        state_next = S_FETCH_LO;
                    end
                    else
                    begin
                        state_next = S_FETCH_A;
                    end
                end
            end

            // read or write: a write merges and writes back; report
            S_FETCH_A:
            begin
                case (command_reg)
                    CMD_WRITE:
                    begin
                        case (channel_reg)
                            CH_RED:   merged[23:16] = wdata_reg[23:16];
                            CH_GREEN: merged[15:8]  = wdata_reg[23:16];
                            CH_BLUE:  merged[7:0]   = wdata_reg[23:16];
                            CH_ALL:   merged        = wdata_reg;
                            default:  merged        = wdata_reg;
                        endcase
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(a_reg);
                        ram_wr_data = merged;
                    end
                    default:
                    begin
                        merged = ram_rd_data;
                    end
                endcase
                out_next          = merged;
                done_next         = 1'b0;
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end

            // low endpoint arrives
            S_FETCH_LO:
            begin
                lo_val_next = ram_rd_data;
                state_next  = S_FETCH_HI;
            end

            // high endpoint arrives: set up dividers and accumulators
            S_FETCH_HI:
            begin
                hi_val_next = ram_rd_data;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    lo_ch       = lo_val_reg[COLOR_W*(NUM_CH-1-c) +: COLOR_W];
                    hi_ch       = ram_rd_data[COLOR_W*(NUM_CH-1-c) +: COLOR_W];
                    neg_next[c] = hi_ch < lo_ch;
                    num_next[c] = {(hi_ch < lo_ch) ? (lo_ch - hi_ch) : (hi_ch - lo_ch),
                                   {FRACTION_BITS{1'b0}}};
                    rem_next[c] = 8'd0;
                    quo_next[c] = {NW{1'b0}};
                    acc_next[c] = {2'b00, lo_ch, {FRACTION_BITS{1'b0}}};
                end
                cnt_next   = CNT_W'(NW - 1);
                state_next = S_DIVIDE;
            end

            // restoring division, one quotient bit per cycle per channel
            S_DIVIDE:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    trial       = {rem_reg[c], num_reg[c][NW-1]};
                    num_next[c] = num_reg[c] << 1;
                    if (trial >= {1'b0, sep_reg})
                    begin
                        rem_next[c] = 8'(trial - {1'b0, sep_reg});
                        quo_next[c] = {quo_reg[c][NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[c] = trial[7:0];
                        quo_next[c] = {quo_reg[c][NW-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    j_next     = lo_reg + 8'd1;
                    state_next = S_FILL;
                end
            end

            // step the accumulators and write one entry per cycle
            S_FILL:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    qx      = {2'b00, quo_reg[c]};
                    acc_sum = neg_reg[c] ? (acc_reg[c] - qx) : (acc_reg[c] + qx);
                    if (acc_sum[ACC_W-1])
                    begin
                        sat = 8'd0;
                    end
                    else if (|acc_sum[ACC_W-2:FRACTION_BITS+COLOR_W])
                    begin
                        sat = 8'hff;
                    end
                    else
                    begin
                        sat = acc_sum[FRACTION_BITS +: COLOR_W];
                    end
                    acc_next[c] = acc_sum;
                    merged[COLOR_W*(NUM_CH-1-c) +: COLOR_W] = sat;
                end
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(j_reg);
                ram_wr_data = merged;
                j_next      = j_reg + 8'd1;
                if (j_reg == hi_reg - 8'd1)
                begin
                    out_next          = (a_reg == lo_reg) ? lo_val_reg : hi_val_reg;
                    done_next         = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
        channel_reg <= channel_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        sep_reg     <= sep_next;
        j_reg       <= j_next;
        wdata_reg   <= wdata_next;
        lo_val_reg  <= lo_val_next;
        hi_val_reg  <= hi_val_next;
        out_reg     <= out_next;
        done_reg    <= done_next;
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        acc_reg     <= acc_next;
    end

    // outputs
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign red_out      = out_reg[23:16];
    assign green_out    = out_reg[15:8];
    assign blue_out     = out_reg[7:0];
    assign blend_done   = done_reg;

endmodule

>>> tb/tb_palette_gradient_fill.sv
`timescale 1ns / 1ps

module tb_palette_gradient_fill;

    import pgf_pkg::*;

    localparam int ENTRIES       = 256;
    localparam int FRACTION_BITS = 16;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int DRAIN_CYCLES  = 320;
    localparam int CYCLE_LIMIT   = 1200000;

    // command code the block treats as a read
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one command as it crosses the start/busy transfer
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] index_a;
        logic [7:0] index_b;
        logic [1:0] channel;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } palette_cmd_t;

    // entry index_a after a command, plus the blend flag
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       blend_done;
    } entry_color_t;

    // directed row: command fields, then a typed-in expectation when known
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] index_a;
        logic [7:0] index_b;
        logic [1:0] channel;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       typed;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       blend_done;
    } directed_row_t;

    localparam int NUM_ROWS = 25;

    // cmd, a, b, channel, r, g, b | typed, expected r, g, b, done
    localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // gray after reset, at both ends
        '{CMD_READ,   8'd0,   8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b1, 8'd0,   8'd0,   8'd0,   1'b0},
        '{CMD_READ,   8'd255, 8'd0,   CH_ALL,   8'd255, 8'd255, 8'd255,
          1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
        // unused command reads and never writes
        '{CMD_UNUSED, 8'd128, 8'd255, CH_ALL,   8'd255, 8'd255, 8'd255,
          1'b1, 8'd128, 8'd128, 8'd128, 1'b0},
        // blends too narrow to change anything
        '{CMD_BLEND,  8'd10,  8'd11,  CH_RED,   8'd0,   8'd0,   8'd0,
          1'b1, 8'd10,  8'd10,  8'd10,  1'b0},
        '{CMD_BLEND,  8'd20,  8'd20,  CH_RED,   8'd0,   8'd0,   8'd0,
          1'b1, 8'd20,  8'd20,  8'd20,  1'b0},
        // single channel writes take red_in
        '{CMD_WRITE,  8'd5,   8'd0,   CH_RED,   8'd255, 8'd0,   8'd0,
          1'b1, 8'd255, 8'd5,   8'd5,   1'b0},
        '{CMD_WRITE,  8'd6,   8'd0,   CH_GREEN, 8'd0,   8'd255, 8'd255,
          1'b1, 8'd6,   8'd0,   8'd6,   1'b0},
        '{CMD_WRITE,  8'd7,   8'd0,   CH_BLUE,  8'd200, 8'd0,   8'd0,
          1'b1, 8'd7,   8'd7,   8'd200, 1'b0},
        // full writes at the ends of the palette
        '{CMD_WRITE,  8'd0,   8'd0,   CH_ALL,   8'd255, 8'd0,   8'd128,
          1'b1, 8'd255, 8'd0,   8'd128, 1'b0},
        '{CMD_WRITE,  8'd255, 8'd0,   CH_ALL,   8'd0,   8'd255, 8'd0,
          1'b1, 8'd0,   8'd255, 8'd0,   1'b1 ^ 1'b1},
        // widest blend, endpoints given high first
        '{CMD_BLEND,  8'd255, 8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b1, 8'd0,   8'd255, 8'd0,   1'b1},
        '{CMD_READ,   8'd128, 8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{CMD_READ,   8'd1,   8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{CMD_READ,   8'd254, 8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        // narrowest blend that fills one entry
        '{CMD_BLEND,  8'd0,   8'd2,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b1, 8'd255, 8'd0,   8'd128, 1'b1},
        '{CMD_READ,   8'd1,   8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        // black to white over three steps
        '{CMD_WRITE,  8'd100, 8'd0,   CH_ALL,   8'd0,   8'd0,   8'd0,
          1'b1, 8'd0,   8'd0,   8'd0,   1'b0},
        '{CMD_WRITE,  8'd103, 8'd0,   CH_ALL,   8'd255, 8'd255, 8'd255,
          1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
        '{CMD_BLEND,  8'd103, 8'd100, CH_RED,   8'd0,   8'd0,   8'd0,
          1'b1, 8'd255, 8'd255, 8'd255, 1'b1},
        '{CMD_READ,   8'd101, 8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{CMD_READ,   8'd102, 8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        // channels rising, flat and falling in one blend
        '{CMD_WRITE,  8'd200, 8'd0,   CH_ALL,   8'd200, 8'd100, 8'd0,
          1'b1, 8'd200, 8'd100, 8'd0,   1'b0},
        '{CMD_WRITE,  8'd210, 8'd0,   CH_ALL,   8'd0,   8'd100, 8'd200,
          1'b1, 8'd0,   8'd100, 8'd200, 1'b0},
        '{CMD_BLEND,  8'd200, 8'd210, CH_RED,   8'd0,   8'd0,   8'd0,
          1'b1, 8'd200, 8'd100, 8'd0,   1'b1},
        '{CMD_READ,   8'd205, 8'd0,   CH_RED,   8'd0,   8'd0,   8'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] command = CMD_READ;
    logic [7:0] index_a = 8'd0;
    logic [7:0] index_b = 8'd0;
    logic [1:0] channel = CH_RED;
    logic [7:0] red_in = 8'd0;
    logic [7:0] green_in = 8'd0;
    logic [7:0] blue_in = 8'd0;
    logic       result_valid;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       blend_done;

    // predicted palette, channel 0 red, 1 green, 2 blue
    logic [7:0] palette_model [ENTRIES][3];
    entry_color_t pending_colors [$];
    int mismatches = 0;
    int cycle_count = 0;
    int recent_lo = 0;
    int recent_hi = 255;

    palette_gradient_fill #(
        .ENTRIES       (ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .index_a      (index_a),
        .index_b      (index_b),
        .channel      (channel),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .result_valid (result_valid),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .blend_done   (blend_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // linear fill strictly between the two endpoints, fixed point steps
    function automatic bit blend_palette(int a, int b);
        int lo;
        int hi;
        int sep;
        longint step [3];
        longint acc [3];
        longint whole;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        sep = hi - lo;
        if (sep < 2)
            return 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            if (palette_model[hi][c] >= palette_model[lo][c])
                step[c] = (longint'(palette_model[hi][c] - palette_model[lo][c])
                           <<< FRACTION_BITS) / longint'(sep);
            else
                step[c] = -((longint'(palette_model[lo][c] - palette_model[hi][c])
                             <<< FRACTION_BITS) / longint'(sep));
            acc[c] = longint'(palette_model[lo][c]) <<< FRACTION_BITS;
        end
        for (int j = lo + 1; j < hi; j++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc[c] += step[c];
                whole = acc[c] >>> FRACTION_BITS;
                if (acc[c] < 0)
                    palette_model[j][c] = 8'd0;
                else if (whole > 255)
                    palette_model[j][c] = 8'd255;
                else
                    palette_model[j][c] = whole[7:0];
            end
        end
        return 1'b1;
    endfunction

    // update the palette for one command and report entry index_a
    function automatic entry_color_t apply_command(palette_cmd_t cmd);
        entry_color_t res;
        int a;
        a = int'(cmd.index_a) % ENTRIES;
        res.blend_done = 1'b0;
        if (cmd.command == CMD_WRITE)
        begin
            case (cmd.channel)
                CH_RED:   palette_model[a][0] = cmd.red_in;
                CH_GREEN: palette_model[a][1] = cmd.red_in;
                CH_BLUE:  palette_model[a][2] = cmd.red_in;
                default:
                begin
                    palette_model[a][0] = cmd.red_in;
                    palette_model[a][1] = cmd.green_in;
                    palette_model[a][2] = cmd.blue_in;
                end
            endcase
        end
        else if (cmd.command == CMD_BLEND)
        begin
            res.blend_done = blend_palette(a, int'(cmd.index_b) % ENTRIES);
        end
        res.red   = palette_model[a][0];
        res.green = palette_model[a][1];
        res.blue  = palette_model[a][2];
        return res;
    endfunction

    // reads, writes, blends and unused codes; half the reads fall in the last blended span
    function automatic palette_cmd_t random_command();
        palette_cmd_t cmd;
        int pick;
        int sep;
        int lo;
        cmd.index_a  = 8'($urandom_range(0, 255));
        cmd.index_b  = 8'($urandom_range(0, 255));
        cmd.channel  = 2'($urandom_range(0, 3));
        cmd.red_in   = 8'($urandom_range(0, 255));
        cmd.green_in = 8'($urandom_range(0, 255));
        cmd.blue_in  = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            cmd.command = CMD_READ;
            if ($urandom_range(0, 1) == 1)
                cmd.index_a = 8'($urandom_range(recent_lo, recent_hi));
        end
        else if (pick < 65)
        begin
            cmd.command = CMD_WRITE;
        end
        else if (pick < 95)
        begin
            cmd.command = CMD_BLEND;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                sep = $urandom_range(0, 12);
            else if (pick < 95)
                sep = $urandom_range(13, 64);
            else
                sep = $urandom_range(65, 255);
            lo = $urandom_range(0, 255 - sep);
            recent_lo = lo;
            recent_hi = lo + sep;
            if ($urandom_range(0, 1) == 1)
            begin
                cmd.index_a = 8'(lo);
                cmd.index_b = 8'(lo + sep);
            end
            else
            begin
                cmd.index_a = 8'(lo + sep);
                cmd.index_b = 8'(lo);
            end
        end
        else
        begin
            cmd.command = CMD_UNUSED;
        end
        return cmd;
    endfunction

    // present one command after a random gap and hold it until the transfer
    task automatic issue_command(input palette_cmd_t cmd);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        command  <= cmd.command;
        index_a  <= cmd.index_a;
        index_b  <= cmd.index_b;
        channel  <= cmd.channel;
        red_in   <= cmd.red_in;
        green_in <= cmd.green_in;
        blue_in  <= cmd.blue_in;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // gray palette to match the clearing pass
    initial
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            for (int c = 0; c < 3; c++)
                palette_model[j][c] = 8'(j % 256);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        entry_color_t want;
        if (rst_n && result_valid)
        begin
            if (pending_colors.size() == 0)
            begin
                $display("%0t: result with none expected, actual %0d %0d %0d done %0d",
                         $time, red_out, green_out, blue_out, blend_done);
                mismatches++;
            end
            else
            begin
                want = pending_colors.pop_front();
                compare_field("red_out", want.red, red_out);
                compare_field("green_out", want.green, green_out);
                compare_field("blue_out", want.blue, blue_out);
                compare_field("blend_done", want.blend_done, blend_done);
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial
    begin
        palette_cmd_t cmd;
        entry_color_t predicted;
        directed_row_t row;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            cmd.command  = row.command;
            cmd.index_a  = row.index_a;
            cmd.index_b  = row.index_b;
            cmd.channel  = row.channel;
            cmd.red_in   = row.red_in;
            cmd.green_in = row.green_in;
            cmd.blue_in  = row.blue_in;
            issue_command(cmd);
            predicted = apply_command(cmd);
            if (row.typed)
            begin
                predicted.red        = row.red;
                predicted.green      = row.green;
                predicted.blue       = row.blue;
                predicted.blend_done = row.blend_done;
            end
            pending_colors.push_back(predicted);
        end

        // random commands
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            cmd = random_command();
            issue_command(cmd);
            pending_colors.push_back(apply_command(cmd));
        end
        start <= 1'b0;

        // drain
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
